// ===== hw/rtl/audio_playback_jitter_buffer_unit_macros.svh =====
// Assertion macros shared by the jitter buffer checker
`ifndef AUDIO_PLAYBACK_JITTER_BUFFER_UNIT_MACROS_SVH
`define AUDIO_PLAYBACK_JITTER_BUFFER_UNIT_MACROS_SVH

// Antecedent implies consequent in the same cycle
`define APJB_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("jitter buffer check failed");

// Antecedent implies consequent in the next cycle
`define APJB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("jitter buffer check failed");

`endif

// ===== hw/rtl/apjb_pkg.sv =====
// Types and constants of the playback jitter buffer
`timescale 1ns / 1ps
`default_nettype none
package apjb_pkg;
	typedef enum logic [1:0] {
		FN_PUSH     = 2'd0,
		FN_RENDER   = 2'd1,
		FN_ACTIVE   = 2'd2,
		FN_FEEDBACK = 2'd3
	} func_t;

	typedef enum logic [0:0] {
		REG_MUTED = 1'b0,
		REG_GAIN  = 1'b1
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXEC,
		ST_MUL_L,
		ST_MUL_R,
		ST_SAT_R,
		ST_FB_NUM,
		ST_DIV,
		ST_RATE,
		ST_FB_OUT,
		ST_DONE
	} state_t;

	typedef struct packed {
		func_t              func;
		logic signed [15:0] left_sample;
		logic signed [15:0] right_sample;
		logic               first_of_block;
		logic [15:0]        block_frames;
		logic               active_flag;
		logic [31:0]        consumed_frames;
		logic [63:0]        now_us;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] left_out;
		logic signed [31:0] right_out;
		logic [21:0]        feedback_rate;
		logic [9:0]         fill_count;
		logic [31:0]        dropped_total;
		logic [31:0]        missing_total;
	} out_item_t;

	localparam logic [31:0] GAIN_RESET = 32'd65536;
	localparam logic signed [31:0] RATE_RESET = 32'sd3145728;
	localparam logic signed [31:0] RATE_MIN = 32'sd3129344;
	localparam logic signed [31:0] RATE_MAX = 32'sd3162112;
	localparam logic [63:0] WINDOW_US = 64'd128000;
	localparam logic signed [18:0] ADJ_LIMIT = 19'sd8192;
	localparam logic [57:0] RATE_LO_Q16 = 58'd3080192;  // 47.0
	localparam logic [57:0] RATE_HI_Q16 = 58'd3211264;  // 49.0
	localparam logic [9:0] MS_PER_S = 10'd1000;
	localparam int unsigned QUOT_BITS = 58;
endpackage
`default_nettype wire

// ===== hw/rtl/apjb_ram.sv =====
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
`default_nettype none
module apjb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]              rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/audio_playback_jitter_buffer_unit.sv =====
// Stereo playback jitter buffer with gain, underrun counting and rate feedback
//
// Input channel (in_valid/in_ready/in_item) takes push, render, set-active and
// feedback-tick items; each gives exactly one result on the output channel
// (out_valid/out_ready/out_item). The block handles one item at a time and
// drops in_ready from acceptance until the item's result sits in the output
// register. An item may be accepted while a previous result still waits.
// Push and set-active items go straight to the result; a render with frames stored
// reads the RAM, then uses one shared multiplier for left then right; a feedback
// tick closing a window runs a restoring divider one quotient bit per cycle over
// 58 bits before the rate update.
// If the receiver stalls, the finished item waits in the block until the
// output register frees, and no further item is taken meanwhile.
// Reset (arst_n low) empties the ring, clears counters and the active flag,
// restores 48.0 as rate estimate, unmutes and sets unity gain. Ring RAM
// contents are not cleared; only written frames are ever read.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 muted, 1 gain).
`timescale 1ns / 1ps
`default_nettype none
module audio_playback_jitter_buffer_unit #(
	parameter int RING_FRAMES = 512,
	parameter int FILL_TARGET = 256
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire apjb_pkg::in_item_t  in_item,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output apjb_pkg::out_item_t    out_item,
	input  wire logic              cfg_we,
	input  wire logic              cfg_index,
	input  wire logic [31:0]       cfg_data
);
	import apjb_pkg::*;

	localparam int HW = $clog2(RING_FRAMES);
	localparam int CW = $clog2(RING_FRAMES + 1);
	localparam logic [CW-1:0] RING_C = CW'(RING_FRAMES);
	localparam logic [15:0] RING_16 = 16'(RING_FRAMES);
	localparam logic signed [14:0] TARGET_S = 15'(FILL_TARGET);

	state_t state_q, state_d;
	in_item_t item_q;
	out_item_t out_q;
	logic out_valid_q;

	logic muted_q;
	logic [31:0] gain_q;
	logic [HW-1:0] head_q;
	logic [CW-1:0] fc_q;
	logic active_q;
	logic [15:0] skip_q;
	logic [31:0] drop_q, miss_q;
	logic [63:0] last_time_q;
	logic [31:0] last_cons_q;
	logic signed [31:0] rate_q;

	logic signed [31:0] res_left_q, res_right_q;
	logic [21:0] res_rate_q;
	logic signed [48:0] prod_q;
	logic [63:0] elapsed_q;
	logic [31:0] delta_q;
	logic [57:0] quot_q;
	logic [63:0] rem_q;
	logic [5:0] cnt_q;

	// Config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			muted_q <= 1'b0;
			gain_q  <= GAIN_RESET;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_MUTED: muted_q <= cfg_data[0];
				REG_GAIN:  gain_q  <= cfg_data;
				default:   muted_q <= muted_q;
			endcase
		end
	end

	// Push decode
	logic        first_w;
	logic [15:0] new_skip, skip_eff;
	logic [CW-1:0] n_kept;
	logic        flush;
	logic [CW-1:0] fc_eff;
	logic [HW-1:0] head_eff;
	logic        full;
	logic [17:0] drop_add;
	logic [CW:0] slot_sum;
	logic [HW-1:0] slot;
	logic        do_write;

	always_comb begin
		first_w  = item_q.first_of_block;
		new_skip = (item_q.block_frames > RING_16) ? item_q.block_frames - RING_16 : 16'd0;
		n_kept   = (item_q.block_frames > RING_16) ? RING_C : CW'(item_q.block_frames);
		flush    = first_w && (({1'b0, fc_q} + {1'b0, n_kept}) > {1'b0, RING_C});
		fc_eff   = flush ? '0 : fc_q;
		head_eff = flush ? '0 : head_q;
		skip_eff = first_w ? new_skip : skip_q;
		full     = (skip_eff == 16'd0) && (fc_eff >= RING_C);
		drop_add = (first_w ? {2'b0, new_skip} : 18'd0)
			+ (flush ? 18'(fc_q) : 18'd0) + (full ? 18'd1 : 18'd0);
		slot_sum = {1'b0, (CW)'(head_eff)} + {1'b0, fc_eff};
		if (slot_sum >= {1'b0, RING_C}) begin
			slot_sum = slot_sum - {1'b0, RING_C};
		end
		slot     = slot_sum[HW-1:0];
		do_write = (state_q == ST_EXEC) && (item_q.func == FN_PUSH) && active_q
			&& (skip_eff == 16'd0) && !full;
	end

	// Ring storage
	logic        rd_en;
	logic [31:0] rd_data;
	assign rd_en = (state_q == ST_EXEC) && (item_q.func == FN_RENDER) && active_q
		&& (fc_q != '0);

	apjb_ram #(.WIDTH(32), .DEPTH(RING_FRAMES)) u_ring (
		.clk   (clk),
		.we    (do_write),
		.waddr (slot),
		.wdata ({item_q.right_sample, item_q.left_sample}),
		.re    (rd_en),
		.raddr (head_q),
		.rdata (rd_data)
	);

	// Shared multiplier and saturation
	logic signed [15:0] mul_a;
	logic signed [48:0] mul_p;
	logic signed [31:0] sat_v;
	always_comb begin
		mul_a = (state_q == ST_MUL_L) ? signed'(rd_data[15:0]) : signed'(rd_data[31:16]);
		mul_p = 49'(mul_a) * signed'({17'd0, gain_q});
		if (prod_q > 49'sh0_7FFF_FFFF) begin
			sat_v = 32'sh7FFF_FFFF;
		end else if (prod_q < -49'sh0_8000_0000) begin
			sat_v = 32'sh8000_0000;
		end else begin
			sat_v = prod_q[31:0];
		end
	end

	// Feedback window front end
	logic [63:0] lt_eff, elapsed_w;
	logic [31:0] lc_eff;
	logic        window;
	always_comb begin
		lt_eff    = (last_time_q == 64'd0) ? item_q.now_us : last_time_q;
		lc_eff    = (last_time_q == 64'd0) ? item_q.consumed_frames : last_cons_q;
		elapsed_w = item_q.now_us - lt_eff;
		window    = elapsed_w >= WINDOW_US;
	end

	// Divider step
	logic [64:0] rem_sh;
	logic        div_ge;
	logic [64:0] rem_sub;
	always_comb begin
		rem_sh  = {rem_q, quot_q[QUOT_BITS-1]};
		div_ge  = rem_sh >= {1'b0, elapsed_q};
		rem_sub = rem_sh - {1'b0, elapsed_q};
	end

	// Rate update and feedback result
	logic        rate_ok;
	logic signed [32:0] diff, step;
	logic signed [18:0] adj;
	logic signed [14:0] fill_err;
	logic signed [32:0] fb_sum;
	logic signed [31:0] fb_clamped;
	always_comb begin
		rate_ok = (quot_q >= RATE_LO_Q16)
			&& ((quot_q < RATE_HI_Q16) || ((quot_q == RATE_HI_Q16) && (rem_q == 64'd0)));
		diff = signed'({10'd0, quot_q[22:0]}) - 33'(rate_q);
		step = (diff < 0) ? -((-diff) >>> 3) : (diff >>> 3);
		fill_err = TARGET_S - signed'(15'(fc_q));
		adj = 19'(fill_err) <<< 4;
		if (adj > ADJ_LIMIT) adj = ADJ_LIMIT;
		if (adj < -ADJ_LIMIT) adj = -ADJ_LIMIT;
		fb_sum = 33'(rate_q) + 33'(adj);
		if (fb_sum < 33'(RATE_MIN)) begin
			fb_clamped = RATE_MIN;
		end else if (fb_sum > 33'(RATE_MAX)) begin
			fb_clamped = RATE_MAX;
		end else begin
			fb_clamped = fb_sum[31:0];
		end
	end

	// Sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_EXEC;
			ST_EXEC: begin
				case (item_q.func)
					FN_RENDER:   state_d = rd_en ? ST_MUL_L : ST_DONE;
					FN_FEEDBACK: state_d = window ? ST_FB_NUM : ST_FB_OUT;
					default:     state_d = ST_DONE;
				endcase
			end
			ST_MUL_L:  state_d = ST_MUL_R;
			ST_MUL_R:  state_d = ST_SAT_R;
			ST_SAT_R:  state_d = ST_DONE;
			ST_FB_NUM: state_d = ST_DIV;
			ST_DIV:    if (cnt_q == 6'd0) state_d = ST_RATE;
			ST_RATE:   state_d = ST_FB_OUT;
			ST_FB_OUT: state_d = ST_DONE;
			ST_DONE:   if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	assign in_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			fc_q        <= '0;
			active_q    <= 1'b0;
			skip_q      <= '0;
			drop_q      <= '0;
			miss_q      <= '0;
			last_time_q <= '0;
			last_cons_q <= '0;
			rate_q      <= RATE_RESET;
			out_valid_q <= 1'b0;
		end else begin
			// Result leaves; a finished item reloads the register below instead
			if (out_valid_q && out_ready && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_EXEC: begin
					case (item_q.func)
						FN_PUSH: begin
							if (active_q) begin
								drop_q <= drop_q + 32'(drop_add);
								head_q <= head_eff;
								if (skip_eff != 16'd0) begin
									skip_q <= skip_eff - 16'd1;
									fc_q   <= fc_eff;
								end else begin
									skip_q <= skip_eff;
									fc_q   <= full ? fc_eff : fc_eff + 1'b1;
								end
							end
						end
						FN_RENDER: begin
							if (active_q) begin
								if (fc_q == '0) begin
									miss_q <= miss_q + 32'd1;
									head_q <= '0;
								end else begin
									head_q <= (32'(head_q) == RING_FRAMES - 1) ? '0
										: head_q + 1'b1;
									fc_q   <= fc_q - 1'b1;
								end
							end
						end
						FN_ACTIVE: begin
							active_q    <= item_q.active_flag;
							head_q      <= '0;
							fc_q        <= '0;
							skip_q      <= '0;
							last_time_q <= '0;
							rate_q      <= RATE_RESET;
						end
						default: begin
							last_time_q <= window ? item_q.now_us : lt_eff;
							last_cons_q <= window ? item_q.consumed_frames : lc_eff;
						end
					endcase
				end
				ST_RATE: if (rate_ok) rate_q <= rate_q + step[31:0];
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (in_valid) item_q <= in_item;
			ST_EXEC: begin
				res_left_q  <= '0;
				res_right_q <= '0;
				res_rate_q  <= '0;
				elapsed_q   <= elapsed_w;
				delta_q     <= item_q.consumed_frames - lc_eff;
			end
			ST_MUL_L: prod_q <= mul_p;
			ST_MUL_R: begin
				res_left_q <= muted_q ? '0 : sat_v;
				prod_q     <= mul_p;
			end
			ST_SAT_R: res_right_q <= muted_q ? '0 : sat_v;
			ST_FB_NUM: begin
				quot_q <= {42'(delta_q) * 42'(MS_PER_S), 16'd0};
				rem_q  <= '0;
				cnt_q  <= 6'(QUOT_BITS - 1);
			end
			ST_DIV: begin
				rem_q  <= div_ge ? rem_sub[63:0] : rem_sh[63:0];
				quot_q <= {quot_q[QUOT_BITS-2:0], div_ge};
				cnt_q  <= cnt_q - 6'd1;
			end
			ST_FB_OUT: res_rate_q <= fb_clamped[21:0];
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_q.left_out      <= res_left_q;
					out_q.right_out     <= res_right_q;
					out_q.feedback_rate <= res_rate_q;
					out_q.fill_count    <= 10'(fc_q);
					out_q.dropped_total <= drop_q;
					out_q.missing_total <= miss_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;
endmodule
`default_nettype wire

// ===== hw/rtl/apjb_checker.sv =====
// Port-level checks of the jitter buffer, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "audio_playback_jitter_buffer_unit_macros.svh"
module apjb_checker #(
	parameter int RING_FRAMES = 512
) (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_valid,
	input wire logic                in_ready,
	input wire logic                out_valid,
	input wire logic                out_ready,
	input wire apjb_pkg::out_item_t out_item
);
	import apjb_pkg::*;

	// Rate field is zero or inside the clamp window
	logic rate_in_window;
	assign rate_in_window = (out_item.feedback_rate == 22'd0)
		|| ((32'(out_item.feedback_rate) >= RATE_MIN)
		&& (32'(out_item.feedback_rate) <= RATE_MAX));

	// A stalled result holds
	`APJB_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_item))
	// Busy in the cycle after each transfer in
	`APJB_ASSERT_NEXT(a_busy_after_in, clk, arst_n, in_valid && in_ready, !in_ready)
	// Fill never exceeds the ring
	`APJB_ASSERT_SAME(a_fill_bound, clk, arst_n, out_valid, 32'(out_item.fill_count) <= RING_FRAMES)
	// Feedback rate is zero or within the clamp window
	`APJB_ASSERT_SAME(a_rate_range, clk, arst_n, out_valid, rate_in_window)
endmodule

bind audio_playback_jitter_buffer_unit apjb_checker #(.RING_FRAMES(RING_FRAMES)) u_apjb_checker (.*);
`default_nettype wire

// ===== tb/audio_playback_jitter_buffer_unit_tb.sv =====
// Self-checking testbench for the playback jitter buffer: ring, render gain, feedback rate
`timescale 1ns / 1ps
`default_nettype none

// Predicts results of the jitter buffer and checks the block's output against them
class jb_scoreboard;
	logic [31:0] ring [512];
	int unsigned head, fill, skip, drops, misses;
	bit active, mute;
	logic [31:0] gain;
	logic [63:0] last_us;
	logic [31:0] last_cnt;
	longint rate;
	apjb_pkg::out_item_t pending[$];
	int errors;
	int n_push, n_render, n_tick, n_active;

	function new();
		head = 0; fill = 0; skip = 0; drops = 0; misses = 0;
		active = 0; mute = 0; gain = 32'd65536;
		last_us = 0; last_cnt = 0; rate = 3145728; errors = 0;
		n_push = 0; n_render = 0; n_tick = 0; n_active = 0;
	endfunction

	function void set_reg(apjb_pkg::reg_idx_t idx, logic [31:0] v);
		if (idx == apjb_pkg::REG_MUTED) mute = v[0];
		else gain = v;
	endfunction

	function logic [31:0] scaled(logic signed [15:0] s);
		longint p;
		p = longint'(s) * longint'({32'd0, gain});
		if (p > 64'sd2147483647) p = 64'sd2147483647;
		if (p < -64'sd2147483648) p = -64'sd2147483648;
		return p[31:0];
	endfunction

	function logic [21:0] tick(logic [31:0] cnt, logic [63:0] now);
		logic [63:0] el, num, q, r;
		longint adj, rr, rq;
		if (last_us == 0) begin
			last_us = now; last_cnt = cnt;
		end
		el = now - last_us;
		if (el >= 64'd128000) begin
			num = {32'd0, cnt - last_cnt} * 64'd1000;
			q = num / el; r = num % el;
			if (q >= 47 && (q < 49 || (q == 49 && r == 0))) begin
				rq = longint'((num << 16) / el);
				rate = rate + (rq - rate) / 8;
			end
			last_us = now; last_cnt = cnt;
		end
		adj = (256 - longint'(fill)) * 16;
		if (adj > 8192) adj = 8192;
		if (adj < -8192) adj = -8192;
		rr = rate + adj;
		if (rr < 3129344) rr = 3129344;
		if (rr > 3162112) rr = 3162112;
		return rr[21:0];
	endfunction

	// Note an accepted input and queue its expected result
	function void note_input(apjb_pkg::in_item_t it);
		apjb_pkg::out_item_t o;
		int unsigned n;
		logic [31:0] e;
		o = '0;
		case (it.func)
			apjb_pkg::FN_PUSH: begin
				n_push++;
				if (active) begin
					if (it.first_of_block) begin
						n = 32'(it.block_frames);
						skip = 0;
						if (n > 512) begin
							drops += n - 512; skip = n - 512; n = 512;
						end
						if (fill + n > 512) begin
							drops += fill; head = 0; fill = 0;
						end
					end
					if (skip > 0) skip--;
					else if (fill >= 512) drops++;
					else begin
						ring[(head + fill) % 512] = {it.right_sample, it.left_sample};
						fill++;
					end
				end
			end
			apjb_pkg::FN_RENDER: begin
				n_render++;
				if (active) begin
					if (fill == 0) begin
						misses++; head = 0;
					end else begin
						e = ring[head];
						head = (head + 1) % 512;
						fill--;
						if (!mute) begin
							o.left_out = scaled(e[15:0]);
							o.right_out = scaled(e[31:16]);
						end
					end
				end
			end
			apjb_pkg::FN_ACTIVE: begin
				n_active++;
				active = it.active_flag;
				head = 0; fill = 0; skip = 0; last_us = 0; rate = 3145728;
			end
			default: begin
				n_tick++;
				o.feedback_rate = tick(it.consumed_frames, it.now_us);
			end
		endcase
		o.fill_count = fill[9:0];
		o.dropped_total = drops;
		o.missing_total = misses;
		pending.push_back(o);
	endfunction

	// One line per mismatch, and count it
	task report(string what, logic [63:0] got, logic [63:0] want);
		errors++;
		$display("mismatch %s: got %0h expected %0h", what, got, want);
	endtask

	// Compare one result transfer with the oldest expectation
	task check_result(apjb_pkg::out_item_t o);
		apjb_pkg::out_item_t w;
		if (pending.size() == 0) begin
			report("result with none expected", 64'd0, 64'd0);
			return;
		end
		w = pending.pop_front();
		if (o.left_out !== w.left_out) report("left_out", o.left_out, w.left_out);
		if (o.right_out !== w.right_out) report("right_out", o.right_out, w.right_out);
		if (o.feedback_rate !== w.feedback_rate)
			report("feedback_rate", o.feedback_rate, w.feedback_rate);
		if (o.fill_count !== w.fill_count) report("fill_count", o.fill_count, w.fill_count);
		if (o.dropped_total !== w.dropped_total)
			report("dropped_total", o.dropped_total, w.dropped_total);
		if (o.missing_total !== w.missing_total)
			report("missing_total", o.missing_total, w.missing_total);
	endtask
endclass

module audio_playback_jitter_buffer_unit_tb;
	import apjb_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	in_item_t in_item = '0;
	logic out_valid;
	logic out_ready = 0;
	out_item_t out_item;
	logic cfg_we = 0;
	logic cfg_index = 0;
	logic [31:0] cfg_data = '0;

	jb_scoreboard sb = new();
	longint cycles = 0;
	bit hold_off = 0;
	logic [63:0] clock_us = 64'd1000;
	logic [31:0] consumed = 0;

	always #5 clk = ~clk;

	audio_playback_jitter_buffer_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Note input transfers and check output transfers at the rising edge
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && in_valid && in_ready) sb.note_input(in_item);
		if (arst_n && out_valid && out_ready) sb.check_result(out_item);
	end

	// Receiver: random stalls, with one long hold-off on request
	initial begin
		int w;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_ready <= 0;
				repeat (3000) @(negedge clk);
				hold_off = 0;
			end
			w = (cycles % 20000 < 5000) ? 0 : $urandom_range(0, 6);
			if (w == 0) out_ready <= 1;
			else begin
				out_ready <= 0;
				repeat (w) @(negedge clk);
				out_ready <= 1;
			end
		end
	end

	// Valid stays up between back-to-back items; it drops only for a gap
	task automatic send(in_item_t it);
		int w;
		w = (cycles % 20000 < 5000) ? 0 : $urandom_range(0, 6);
		if (w != 0) begin
			in_valid <= 0;
			repeat (w) @(negedge clk);
		end
		in_item <= it;
		in_valid <= 1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [31:0] v);
		drain();
		cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
		@(negedge clk);
		cfg_we <= 0;
		sb.set_reg(idx, v);
	endtask

	function automatic in_item_t rnd_fields();
		in_item_t it;
		it = '0;
		it.left_sample = 16'($urandom);
		it.right_sample = 16'($urandom);
		it.active_flag = 1;
		return it;
	endfunction

	task automatic push(logic signed [15:0] l, logic signed [15:0] r, bit first, int n);
		in_item_t it;
		it = rnd_fields();
		it.func = FN_PUSH; it.left_sample = l; it.right_sample = r;
		it.first_of_block = first; it.block_frames = 16'(n);
		send(it);
	endtask

	task automatic render();
		in_item_t it;
		it = rnd_fields();
		it.func = FN_RENDER;
		send(it);
	endtask

	task automatic set_active(bit a);
		in_item_t it;
		it = rnd_fields();
		it.func = FN_ACTIVE; it.active_flag = a;
		send(it);
	endtask

	task automatic fb_tick(logic [31:0] cnt, logic [63:0] now);
		in_item_t it;
		it = rnd_fields();
		it.func = FN_FEEDBACK; it.consumed_frames = cnt; it.now_us = now;
		send(it);
	endtask

	// Host block of random frames; sometimes an oversize or ragged block
	task automatic host_block(int n, int sent);
		for (int i = 0; i < sent; i++)
			push(16'($urandom), 16'($urandom), i == 0, n);
	endtask

	// Ticks paced near 48 frames per ms, sometimes off-rate or short windows
	task automatic timed_tick();
		int el;
		int fr;
		case ($urandom_range(0, 5))
			0: el = $urandom_range(1000, 127999);
			1: el = 128000;
			default: el = $urandom_range(128000, 400000);
		endcase
		fr = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 60) * el / 1000
			: $urandom_range(47000, 49000) * (el / 1000) / 1000;
		clock_us = clock_us + el;
		consumed = consumed + fr;
		fb_tick(consumed, clock_us);
	endtask

	// Cycle limit
	initial begin
		wait (cycles > 2000000);
		$display("status: fail");
		$finish;
	end

	initial begin
		in_item_t it;
		int k;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed: inactive items, extremes, overflow, underrun, saturation
		push(16'sh7fff, 16'sh8000, 1, 4);
		render();
		fb_tick(32'hffff_ffff, 64'hffff_ffff_ffff_ffff);
		set_active(1);
		render();
		push(16'sh7fff, 16'sh8000, 1, 3);
		push(16'sh8000, 16'sh7fff, 0, 3);
		push(16'sh0000, 16'shffff, 0, 3);
		render(); render(); render();
		host_block(515, 6);
		host_block(65535, 2);
		push(16'sh1234, 16'sh4321, 0, 0);
		fb_tick(32'd1000, 64'd5000);
		fb_tick(32'd7144, 64'd133000);
		fb_tick(32'd0, 64'hffff_ffff_ffff_ffff);
		set_active(0);
		write_reg(REG_GAIN, 32'hffff_ffff);
		set_active(1);
		push(16'sh7fff, 16'sh8000, 1, 2);
		push(16'sh0001, 16'shffff, 0, 2);
		render(); render();
		write_reg(REG_GAIN, 32'd0);
		write_reg(REG_MUTED, 32'd1);
		push(16'sh0100, 16'sh0100, 1, 1);
		render();
		write_reg(REG_MUTED, 32'd0);
		write_reg(REG_GAIN, 32'd65536);

		// Random phases with varied settings
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				1: write_reg(REG_GAIN, $urandom);
				2: write_reg(REG_MUTED, 32'd1);
				3: begin write_reg(REG_MUTED, 32'd0); write_reg(REG_GAIN, 32'd131072); end
				4: write_reg(REG_GAIN, $urandom_range(0, 65536));
				5: write_reg(REG_GAIN, 32'd65536);
				default: ;
			endcase
			if (ph == 3) begin
				// Stall the receiver while items keep coming
				hold_off = 1;
				for (int i = 0; i < 20; i++) render();
			end
			k = 0;
			while (k < 270) begin
				case ($urandom_range(0, 19))
					0: begin set_active($urandom_range(0, 5) != 0); k++; end
					1, 2, 3: begin timed_tick(); k++; end
					4: begin
						it = 148'({$urandom, $urandom, $urandom, $urandom, $urandom});
						send(it); k++;
					end
					5, 6, 7, 8, 9, 10: begin
						int n;
						int sent;
						n = ($urandom_range(0, 9) == 0) ? $urandom_range(500, 700)
							: $urandom_range(0, 48);
						sent = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n) : n;
						if (sent > 40) sent = $urandom_range(0, 40);
						host_block(n, sent); k += sent;
					end
					default: begin
						int m;
						m = $urandom_range(1, 30);
						for (int i = 0; i < m; i++) render();
						k += m;
					end
				endcase
			end
		end
		drain();
		$display("covered %0d pushes, %0d renders, %0d ticks, %0d activations",
			sb.n_push, sb.n_render, sb.n_tick, sb.n_active);
		$display("frames dropped %0d, underruns %0d", sb.drops, sb.misses);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule
`default_nettype wire
